[rtl/fpfa_pkg.sv]
package fpfa_pkg;

	typedef struct packed {
		logic        kind;
		logic [3:0]  block_index;
		logic [15:0] size_value;
	} req_item_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_block;
		logic [15:0] chosen_size;
	} rsp_item_t;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam int CFG_DATA_BITS = 5;
	localparam logic REG_FIT_MODE      = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;
	localparam logic [CFG_DATA_BITS-1:0] BLOCKS_IN_USE_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

[rtl/fixed_partition_fit_allocator.sv]
// Fixed-partition allocator with first, best and worst fit placement.
// Request channel (req_valid / req_stall / req): a load item writes a block
// size and frees that block; a request item searches the free blocks below
// blocks_in_use for one at least as large as size_value and marks it used.
// Response channel (rsp_valid / rsp_stall / rsp): one item per accepted item,
// in order, with granted, chosen_block and chosen_size (zeros on no grant).
// Config port (cfg_we / cfg_index / cfg_data): 0 fit_mode, 1 blocks_in_use;
// write only while the block is idle.
// One item at a time: req_stall is high from acceptance until the result is
// moved into the response register. A load passes from idle to the finish
// state. A request passes through the scan state, where L = min(blocks_in_use,
// MAX_BLOCKS) entries of the size memory are read one entry per cycle through
// its single registered read port; the scan closes once the last entry read is
// tested. In the finish state, once the response register is free, the used
// mark is written back and the result is posted.
// The response register lets the next item be accepted while a result waits;
// if rsp_stall holds, the following result waits in place and req_stall stays.
// Reset marks every block used (nothing free), fit_mode 0, blocks_in_use 16;
// the size memory is not cleared and needs no clearing pass.
module fixed_partition_fit_allocator #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  fpfa_pkg::req_item_t                  req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output fpfa_pkg::rsp_item_t                  rsp,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [fpfa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int LW  = (CW > fpfa_pkg::CFG_DATA_BITS) ? CW : fpfa_pkg::CFG_DATA_BITS;

	fpfa_pkg::state_t state_q;
	logic [1:0]                         fit_mode_q;
	logic [fpfa_pkg::CFG_DATA_BITS-1:0] blocks_q;
	logic [MAX_BLOCKS-1:0]              used_q;
	logic                               is_req_q;
	logic                               found_q;
	logic [IW-1:0]                      best_idx_q;
	logic [SIZE_BITS-1:0]               best_size_q;
	logic [SIZE_BITS-1:0]               want_q;
	logic [LW-1:0]                      rd_cnt_q;
	logic                               eval_vld_s1;
	logic [IW-1:0]                      eval_idx_s1;
	logic                               rsp_valid_q;
	fpfa_pkg::rsp_item_t                rsp_q;

	logic                 accept;
	logic [LW-1:0]        blocks_w;
	logic [LW-1:0]        limit;
	logic                 issue;
	logic [31:0]          req_size_ext;
	logic [SIZE_BITS-1:0] req_size;
	logic [7:0]           load_idx_ext;
	logic [IW-1:0]        load_addr;
	logic                 load_ok;
	logic                 mem_we;
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic                 fits;
	logic                 take;
	logic                 out_free;
	logic [7:0]           best_idx_ext;
	logic [31:0]          best_size_ext;

	assign accept       = req_valid && !req_stall;
	assign req_stall    = (state_q != fpfa_pkg::ST_IDLE);
	assign blocks_w     = LW'(blocks_q);
	assign limit        = (blocks_w > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : blocks_w;
	assign issue        = (state_q == fpfa_pkg::ST_SCAN) && (rd_cnt_q < limit);
	assign req_size_ext = 32'(req.size_value);
	assign req_size     = req_size_ext[SIZE_BITS-1:0];
	assign load_idx_ext = 8'(req.block_index);
	assign load_addr    = load_idx_ext[IW-1:0];
	assign load_ok      = 9'(req.block_index) < 9'(MAX_BLOCKS);
	assign mem_we       = accept && (req.kind == fpfa_pkg::KIND_LOAD) && load_ok;
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign best_idx_ext  = 8'(best_idx_q);
	assign best_size_ext = 32'(best_size_q);

	fpfa_size_ram #(
		.DEPTH(MAX_BLOCKS),
		.WIDTH(SIZE_BITS)
	) u_size_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(load_addr),
		.wdata(req_size),
		.raddr(rd_cnt_q[IW-1:0]),
		.rdata(rd_size_s1)
	);

	// candidate test and policy compare on the entry read last cycle
	always_comb begin
		fits = eval_vld_s1 && !used_q[eval_idx_s1] && (rd_size_s1 >= want_q);
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == fpfa_pkg::FIT_BEST) begin
				take = rd_size_s1 < best_size_q;
			end else if (fit_mode_q == fpfa_pkg::FIT_WORST) begin
				take = rd_size_s1 > best_size_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= fpfa_pkg::FIT_FIRST;
			blocks_q   <= fpfa_pkg::BLOCKS_IN_USE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpfa_pkg::REG_FIT_MODE:      fit_mode_q <= cfg_data[1:0];
				fpfa_pkg::REG_BLOCKS_IN_USE: blocks_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpfa_pkg::ST_IDLE;
			used_q      <= '1;
			found_q     <= 1'b0;
			is_req_q    <= 1'b0;
			rd_cnt_q    <= '0;
			eval_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			eval_vld_s1 <= issue;
			if (state_q == fpfa_pkg::ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				fpfa_pkg::ST_IDLE: begin
					if (accept) begin
						is_req_q <= req.kind;
						rd_cnt_q <= '0;
						if (req.kind == fpfa_pkg::KIND_LOAD) begin
							found_q <= load_ok;
							if (load_ok) begin
								used_q[load_addr] <= 1'b0;
							end
							state_q <= fpfa_pkg::ST_FIN;
						end else begin
							found_q <= 1'b0;
							state_q <= fpfa_pkg::ST_SCAN;
						end
					end
				end
				fpfa_pkg::ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue && !eval_vld_s1) begin
						state_q <= fpfa_pkg::ST_FIN;
					end
				end
				fpfa_pkg::ST_FIN: begin
					if (out_free) begin
						if (is_req_q && found_q) begin
							used_q[best_idx_q] <= 1'b1;
						end
						state_q <= fpfa_pkg::ST_IDLE;
					end
				end
				default: state_q <= fpfa_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			want_q      <= req_size;
			best_idx_q  <= load_addr;
			best_size_q <= req_size;
		end else if (take) begin
			best_idx_q  <= eval_idx_s1;
			best_size_q <= rd_size_s1;
		end
		eval_idx_s1 <= rd_cnt_q[IW-1:0];
		if (state_q == fpfa_pkg::ST_FIN && out_free) begin
			rsp_q.granted      <= found_q;
			rsp_q.chosen_block <= found_q ? best_idx_ext[3:0] : 4'd0;
			rsp_q.chosen_size  <= found_q ? best_size_ext[15:0] : 16'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/fpfa_size_ram.sv]
module fpfa_size_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
